// ===== rtl/core/ciss_pkg.sv =====
package ciss_pkg;

    // sizing of the search
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int POSITION_BITS     = 16;
    localparam int PATTERN_CAP       = (MAX_PATTERN_BYTES < 16) ? MAX_PATTERN_BYTES : 16;
    localparam int COUNT_BITS        = POSITION_BITS + 1;

    // fixed field widths
    localparam int BYTE_BITS     = 8;
    localparam int LENGTH_BITS   = 5;
    localparam int MATCH_POS_BITS = 16;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LEN  = 2'd2;

    typedef logic [15:0][BYTE_BITS-1:0]          t_pat_bytes;
    typedef logic [PATTERN_CAP-1:0][BYTE_BITS-1:0] t_window;

    // folded pattern as held by the configuration block
    typedef struct packed {
        t_pat_bytes              bytes;
        logic [LENGTH_BITS-1:0]  length;
    } t_pattern;

    // compare outcome for one byte
    typedef struct packed {
        logic                     hit;
        logic [POSITION_BITS-1:0] start;
    } t_match;

    // ascii upper case to lower case, everything else untouched
    function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] b);
        logic [BYTE_BITS-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ciss_in_if.sv =====
interface ciss_in_if;
    import ciss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_byte;
    logic                 last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ciss_out_if.sv =====
interface ciss_out_if;
    import ciss_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [MATCH_POS_BITS-1:0] match_position;
    logic                      overflow;

    modport source (output valid, output found, output match_position, output overflow,
                    input ready);
    modport sink   (input valid, input found, input match_position, input overflow,
                    output ready);
endinterface

// ===== rtl/core/ciss_cfg.sv =====
module ciss_cfg
    import ciss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_pattern                 o_pattern
);

    t_pat_bytes             r_bytes;
    t_pat_bytes             n_bytes;
    logic [LENGTH_BITS-1:0] r_length;
    logic [LENGTH_BITS-1:0] n_length;

    // pattern is folded once on write
    always_comb begin
        n_bytes  = r_bytes;
        n_length = r_length;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LOW: begin
                    for (int j = 0; j < 8; j++) begin
                        n_bytes[j] = fold_byte(i_cfg_wdata[j*8 +: 8]);
                    end
                end
                CFG_PAT_HIGH: begin
                    for (int j = 0; j < 8; j++) begin
                        n_bytes[j+8] = fold_byte(i_cfg_wdata[j*8 +: 8]);
                    end
                end
                CFG_PAT_LEN: begin
                    n_length = i_cfg_wdata[LENGTH_BITS-1:0];
                end
                default: begin
                    n_length = r_length;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes  <= '0;
            r_length <= '0;
        end else begin
            r_bytes  <= n_bytes;
            r_length <= n_length;
        end
    end

    assign o_pattern.bytes  = r_bytes;
    assign o_pattern.length = r_length;

endmodule

// ===== rtl/core/ciss_match.sv =====
module ciss_match
    import ciss_pkg::*;
(
    input  t_window                 i_window,
    input  t_pattern                i_pattern,
    input  logic [COUNT_BITS-1:0]   i_count,
    input  logic                    i_seen,
    output t_match                  o_match
);

    logic [BYTE_BITS-1:0]   sel [PATTERN_CAP];
    logic [PATTERN_CAP-1:0] ok;
    logic [COUNT_BITS-1:0]  len_ext;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   len_fits;
    logic                   equal;

    assign len_ext   = COUNT_BITS'(i_pattern.length);
    assign count_inc = i_count + COUNT_BITS'(1);
    assign len_fits  = (i_pattern.length <= LENGTH_BITS'(PATTERN_CAP)) && (len_ext <= count_inc);

    // pattern byte j lines up with window byte length-1-j
    always_comb begin
        for (int j = 0; j < PATTERN_CAP; j++) begin
            sel[j] = '0;
            for (int k = 0; k < PATTERN_CAP; k++) begin
                if (6'(i_pattern.length) == 6'(j + k + 1)) begin
                    sel[j] = i_window[k];
                end
            end
            ok[j] = (6'(i_pattern.length) <= 6'(j)) || (sel[j] == i_pattern.bytes[j]);
        end
    end

    assign equal = &ok;

    assign o_match.hit   = !i_seen && !i_count[POSITION_BITS] && len_fits && equal;
    assign o_match.start = (i_pattern.length == '0) ? '0
                         : POSITION_BITS'(count_inc - len_ext);

endmodule

// ===== rtl/core/case_insensitive_substring_search_core.sv =====
// case-insensitive substring search over a byte stream
//
// i_in carries one text word per handshake (text_byte, last_byte); last_byte
// closes a text. o_out carries one word per text: found, match_position
// (start of the first match, 0 when not found) and overflow (text ran past
// the position counter). The user must write the pattern (up to 16 bytes)
// and length over the i_cfg_* port while no text is in flight; not enforced.
//
// a taken byte sits in the input register, where the compare runs; a last
// byte then loads the result register once it is free. throughput is one
// byte per cycle while no last byte waits for the result register, set by
// the single compare stage between the input and result registers.
//
// reset clears the pattern, the per-text state and the valid flags of both
// registers. when the receiver stalls, bytes that close no text keep
// flowing; a last byte waits in the input register with i_in.ready low until
// the output register is free.
module case_insensitive_substring_search_core
    import ciss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ciss_in_if.sink                  i_in,
    ciss_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_pattern pattern;
    t_match   match;
    t_window  window_next;

    // input register
    logic                      r_in_valid;
    logic [BYTE_BITS-1:0]      r_in_byte;
    logic                      r_in_last;

    // per-text state
    t_window                   r_window;
    logic [COUNT_BITS-1:0]     r_count;
    logic [COUNT_BITS-1:0]     n_count;
    logic                      r_seen;
    logic                      n_seen;
    logic [POSITION_BITS-1:0]  r_start;
    logic [POSITION_BITS-1:0]  n_start;
    logic                      r_ovf;
    logic                      n_ovf;

    // result register
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [MATCH_POS_BITS-1:0] r_out_pos;
    logic                      r_out_ovf;

    logic advance;
    logic take_in;

    ciss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pattern   (pattern)
    );

    // window after shifting in the current byte
    always_comb begin
        window_next[0] = r_in_byte;
        for (int k = 1; k < PATTERN_CAP; k++) begin
            window_next[k] = r_window[k-1];
        end
    end

    ciss_match u_match (
        .i_window  (window_next),
        .i_pattern (pattern),
        .i_count   (r_count),
        .i_seen    (r_seen),
        .o_match   (match)
    );

    // a last byte needs a free result slot, other bytes always move on
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign take_in = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    // next per-text state
    always_comb begin
        n_ovf   = r_ovf | r_count[POSITION_BITS];
        n_count = r_count[POSITION_BITS] ? r_count : r_count + COUNT_BITS'(1);
        n_seen  = r_seen | match.hit;
        n_start = match.hit ? match.start : r_start;
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= fold_byte(i_in.text_byte);
            r_in_last <= i_in.last_byte;
        end
    end

    // window holds only bytes of the current text where it is compared
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_window <= window_next;
        end
    end

    // per-text state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
            r_ovf   <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_start <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_seen  <= n_seen;
                r_start <= n_start;
                r_ovf   <= n_ovf;
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_found <= n_seen;
            r_out_pos   <= n_seen ? MATCH_POS_BITS'(n_start) : '0;
            r_out_ovf   <= n_ovf;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out_found;
    assign o_out.match_position = r_out_pos;
    assign o_out.overflow       = r_out_ovf;

endmodule
